>>> rtl/scpc_pkg.sv
// shared types and constants for the serial command pwm controller
// used by scpc_mac and serial_command_pwm_controller; no dependencies
package scpc_pkg;

	localparam int LINE_CAP_DEF = 30;

	// command transfer payload
	typedef struct packed {
		logic       req_type;
		logic [7:0] rx_byte;
		logic [9:0] adc_sample;
	} cmd_item_t;

	// report transfer payload
	typedef struct packed {
		logic [1:0]         report_kind;
		logic signed [15:0] report_value;
		logic [9:0]         pwm_duty;
		logic               emergency_active;
	} rpt_item_t;

	// request codes
	localparam logic REQ_BYTE      = 1'b0;
	localparam logic REQ_EMERGENCY = 1'b1;

	// report codes
	localparam logic [1:0] KIND_NOTICE  = 2'd0;
	localparam logic [1:0] KIND_TEMP    = 2'd1;
	localparam logic [1:0] KIND_PERCENT = 2'd2;

	// characters
	localparam logic [7:0] CHAR_NUL     = 8'd0;
	localparam logic [7:0] CHAR_NEWLINE = 8'd10;
	localparam logic [7:0] CHAR_ZERO    = 8'd48;

	// command words
	localparam int TEMP_LEN = 9;
	localparam int REAN_LEN = 8;
	localparam int CTRL_LEN = 5;
	localparam logic [7:0] TEMP_WORD [TEMP_LEN] = '{"l", "e", "e", "r", "_", "t", "e", "m", "p"};
	localparam logic [7:0] REAN_WORD [REAN_LEN] = '{"r", "e", "a", "n", "u", "d", "a", "r"};
	localparam logic [7:0] CTRL_WORD [CTRL_LEN] = '{"c", "t", "r", "l", ":"};

	// shared multiply-add unit
	localparam int MAC_W = 19;
	typedef logic signed [MAC_W-1:0]   mac_op_t;
	typedef logic signed [2*MAC_W-1:0] mac_res_t;

	typedef struct packed {
		logic    en;
		mac_op_t a;
		mac_op_t b;
		mac_op_t c;
	} mac_req_t;

	// fixed-point constants
	localparam int TEMP_SLOPE  = 205;
	localparam int TEMP_OFFSET = 56320;
	localparam int TEMP_SHIFT  = 10;
	localparam int DUTY_SCALE  = 1023;
	localparam int DUTY_MAX    = 1023;
	localparam int PCT_MAX     = 100;
	localparam int RECIP_100   = 167773;
	localparam int RECIP_SHIFT = 24;

endpackage

>>> rtl/scpc_mac.sv
// shared signed multiply-add unit with a registered result
// depends on scpc_pkg
module scpc_mac
	import scpc_pkg::*;
(
	input  logic     clk,
	input  mac_req_t req,
	output mac_res_t res
);

	mac_res_t res_q;

	always_ff @(posedge clk) begin
		if (req.en) begin
			res_q <= mac_res_t'(req.a * req.b) + mac_res_t'(req.c);
		end
	end

	assign res = res_q;

endmodule

>>> rtl/serial_command_pwm_controller.sv
// top level of the serial command pwm controller: line memory, sequencer, report register
// depends on scpc_pkg and scpc_mac
//
// Serial bytes and emergency-pin events arrive one per transfer on the cmd channel; results
// leave on the rpt channel. A non-newline byte (or a zero byte, which is dropped) is stored in
// the cycle of its transfer and the block is ready again on the next cycle. An emergency event
// latches the lockout, forces the duty to 0 and queues a notice. A newline is evaluated by one
// small sequencer: the line memory has a single registered read port, so the first
// min(length, 9) characters are each read and then compared, then a decision is taken, then
// the sequencer drives the one shared multiply-add unit (at most five steps: three of digit
// accumulation and two of percent to duty scaling, or one temperature slope) and hands the
// report over. The block is not ready while a line is evaluated. The report register sits
// between the sequencer and the rpt channel, so new commands are taken while a report waits;
// the sequencer only stalls when it has a second report and the first one has not been taken.
module serial_command_pwm_controller
	import scpc_pkg::*;
#(
	parameter int LINE_CAP = LINE_CAP_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_ready,
	input  cmd_item_t cmd,
	output logic      rpt_valid,
	input  logic      rpt_ready,
	output rpt_item_t rpt
);

	localparam int IW = $clog2(LINE_CAP);

	// sequencer states
	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_RD     = 4'd1;
	localparam logic [3:0] ST_CMP    = 4'd2;
	localparam logic [3:0] ST_DECIDE = 4'd3;
	localparam logic [3:0] ST_DIG    = 4'd4;
	localparam logic [3:0] ST_PCT    = 4'd5;
	localparam logic [3:0] ST_DUTY_A = 4'd6;
	localparam logic [3:0] ST_DUTY_B = 4'd7;
	localparam logic [3:0] ST_DUTY_C = 4'd8;
	localparam logic [3:0] ST_TEMP_A = 4'd9;
	localparam logic [3:0] ST_TEMP_B = 4'd10;
	localparam logic [3:0] ST_EMIT   = 4'd11;

	logic [3:0] state_q;

	// line memory and its fill position
	logic [7:0]    line_mem [LINE_CAP];
	logic [7:0]    rd_data_q;
	logic [IW-1:0] rd_addr;
	logic [IW-1:0] line_len_q;
	logic [IW-1:0] eval_len_q;

	// scan of the stored line
	logic [3:0] scan_idx_q;
	logic [3:0] scan_lim_q;
	logic       temp_ok_q;
	logic       rean_ok_q;
	logic       ctrl_ok_q;
	logic [7:0] dig_q [3];
	logic [3:0] dig_pos;

	// digit loop
	logic [1:0] dig_idx_q;
	logic [1:0] dig_cnt_q;

	// architectural state
	logic               lock_q;
	logic signed [15:0] pct_q;
	logic [9:0]         duty_q;
	logic [9:0]         adc_q;

	// pending report
	logic [1:0]         emit_kind_q;
	logic signed [15:0] emit_val_q;

	// report register
	logic      rpt_valid_q;
	rpt_item_t rpt_q;

	// shared unit
	mac_req_t mac_req;
	mac_res_t mac_res;

	logic cmd_xfer;
	logic emit_go;
	logic temp_hit;
	logic rean_hit;
	logic ctrl_hit;
	logic num_ok;

	logic signed [MAC_W-1:0] temp_num;
	logic signed [MAC_W-1:0] temp_adj;
	logic signed [15:0]      temp_val;

	assign cmd_ready = (state_q == ST_IDLE);
	assign cmd_xfer  = cmd_valid && cmd_ready;
	assign emit_go   = (state_q == ST_EMIT) && (!rpt_valid_q || rpt_ready);

	assign rd_addr = IW'(scan_idx_q);
	assign dig_pos = scan_idx_q - 4'd5;

	// length checks on the captured line
	assign temp_hit = temp_ok_q && (eval_len_q == IW'(TEMP_LEN));
	assign rean_hit = rean_ok_q && (eval_len_q == IW'(REAN_LEN));
	assign ctrl_hit = ctrl_ok_q && (eval_len_q >= IW'(CTRL_LEN));
	// one to three characters after the prefix
	assign num_ok   = (eval_len_q >= IW'(CTRL_LEN + 1)) && (eval_len_q <= IW'(CTRL_LEN + 3));

	// temperature: truncate toward zero when dividing by 1024
	assign temp_num = mac_res[MAC_W-1:0];
	assign temp_adj = temp_num + (temp_num[MAC_W-1] ? MAC_W'((1 << TEMP_SHIFT) - 1) : '0);
	assign temp_val = 16'(temp_adj >>> TEMP_SHIFT);

	// line memory: one write at the byte transfer, one registered read
	always_ff @(posedge clk) begin
		if (cmd_xfer && cmd.req_type == REQ_BYTE && cmd.rx_byte != CHAR_NUL
			&& cmd.rx_byte != CHAR_NEWLINE) begin
			line_mem[line_len_q] <= cmd.rx_byte;
		end
		rd_data_q <= line_mem[rd_addr];
	end

	// operand selection for the shared multiply-add unit
	always_comb begin
		mac_req = '0;
		case (state_q)
			ST_DIG: begin
				mac_req.en = 1'b1;
				mac_req.a  = (dig_idx_q == 2'd0) ? '0 : mac_res[MAC_W-1:0];
				mac_req.b  = MAC_W'(10);
				mac_req.c  = $signed({{(MAC_W-8){1'b0}}, dig_q[dig_idx_q]})
					- $signed(MAC_W'(CHAR_ZERO));
			end
			ST_DUTY_A: begin
				mac_req.en = 1'b1;
				mac_req.a  = MAC_W'(pct_q);
				mac_req.b  = MAC_W'(DUTY_SCALE);
			end
			ST_DUTY_B: begin
				mac_req.en = 1'b1;
				mac_req.a  = mac_res[MAC_W-1:0];
				mac_req.b  = MAC_W'(RECIP_100);
			end
			ST_TEMP_A: begin
				mac_req.en = 1'b1;
				mac_req.a  = $signed({{(MAC_W-10){1'b0}}, adc_q});
				mac_req.b  = MAC_W'(TEMP_SLOPE);
				mac_req.c  = -MAC_W'(TEMP_OFFSET);
			end
			default: begin
				mac_req = '0;
			end
		endcase
	end

	scpc_mac u_mac (
		.clk (clk),
		.req (mac_req),
		.res (mac_res)
	);

	// payload registers of the sequencer, no reset needed
	always_ff @(posedge clk) begin
		if (cmd_xfer) begin
			adc_q      <= cmd.adc_sample;
			eval_len_q <= line_len_q;
			scan_lim_q <= (line_len_q > IW'(TEMP_LEN)) ? 4'(TEMP_LEN) : 4'(line_len_q);
			scan_idx_q <= '0;
			temp_ok_q  <= 1'b1;
			rean_ok_q  <= 1'b1;
			ctrl_ok_q  <= 1'b1;
		end
		if (state_q == ST_CMP) begin
			// compare one stored character against every command word
			if (scan_idx_q < 4'(TEMP_LEN) && rd_data_q != TEMP_WORD[scan_idx_q]) begin
				temp_ok_q <= 1'b0;
			end
			if (scan_idx_q < 4'(REAN_LEN) && rd_data_q != REAN_WORD[scan_idx_q[2:0]]) begin
				rean_ok_q <= 1'b0;
			end
			if (scan_idx_q < 4'(CTRL_LEN) && rd_data_q != CTRL_WORD[scan_idx_q[2:0]]) begin
				ctrl_ok_q <= 1'b0;
			end
			// keep the digits after the prefix
			if (scan_idx_q >= 4'(CTRL_LEN) && scan_idx_q < 4'(CTRL_LEN + 3)) begin
				dig_q[dig_pos[1:0]] <= rd_data_q;
			end
			scan_idx_q <= scan_idx_q + 4'd1;
		end
		if (state_q == ST_DECIDE) begin
			dig_idx_q <= '0;
			dig_cnt_q <= 2'(eval_len_q - IW'(CTRL_LEN));
		end
		if (state_q == ST_DIG) begin
			dig_idx_q <= dig_idx_q + 2'd1;
		end
	end

	// sequencer and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			line_len_q  <= '0;
			lock_q      <= 1'b0;
			pct_q       <= '0;
			duty_q      <= '0;
			emit_kind_q <= KIND_NOTICE;
			emit_val_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd_xfer) begin
						if (cmd.req_type == REQ_EMERGENCY) begin
							lock_q      <= 1'b1;
							duty_q      <= '0;
							emit_kind_q <= KIND_NOTICE;
							emit_val_q  <= '0;
							state_q     <= ST_EMIT;
						end else if (cmd.rx_byte == CHAR_NEWLINE) begin
							// the line is consumed whatever it holds
							line_len_q <= '0;
							state_q    <= (line_len_q == '0) ? ST_DECIDE : ST_RD;
						end else if (cmd.rx_byte != CHAR_NUL) begin
							// write position wraps at the line capacity
							line_len_q <= (line_len_q == IW'(LINE_CAP - 1)) ? '0
								: line_len_q + IW'(1);
						end
					end
				end
				ST_RD: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					state_q <= (scan_idx_q + 4'd1 == scan_lim_q) ? ST_DECIDE : ST_RD;
				end
				ST_DECIDE: begin
					if (lock_q) begin
						if (rean_hit) begin
							lock_q  <= 1'b0;
							state_q <= ST_IDLE;
						end else if (temp_hit || ctrl_hit) begin
							emit_kind_q <= KIND_NOTICE;
							emit_val_q  <= '0;
							state_q     <= ST_EMIT;
						end else begin
							state_q <= ST_IDLE;
						end
					end else if (temp_hit) begin
						state_q <= ST_TEMP_A;
					end else if (ctrl_hit) begin
						// empty or over-long number keeps the previous percent
						state_q <= num_ok ? ST_DIG : ST_DUTY_A;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_DIG: begin
					if (dig_idx_q + 2'd1 == dig_cnt_q) begin
						state_q <= ST_PCT;
					end
				end
				ST_PCT: begin
					pct_q   <= mac_res[15:0];
					state_q <= ST_DUTY_A;
				end
				ST_DUTY_A: begin
					emit_kind_q <= KIND_PERCENT;
					emit_val_q  <= pct_q;
					// out-of-range percents saturate without the divide
					if (pct_q < 16'sd0) begin
						duty_q  <= '0;
						state_q <= ST_EMIT;
					end else if (pct_q > 16'(PCT_MAX)) begin
						duty_q  <= 10'(DUTY_MAX);
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_DUTY_B;
					end
				end
				ST_DUTY_B: begin
					state_q <= ST_DUTY_C;
				end
				ST_DUTY_C: begin
					// divide by 100 through the scaled reciprocal
					duty_q  <= mac_res[RECIP_SHIFT +: 10];
					state_q <= ST_EMIT;
				end
				ST_TEMP_A: begin
					state_q <= ST_TEMP_B;
				end
				ST_TEMP_B: begin
					emit_kind_q <= KIND_TEMP;
					emit_val_q  <= temp_val;
					state_q     <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// report register, loaded when empty or being drained
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rpt_valid_q <= 1'b0;
		end else if (emit_go) begin
			rpt_valid_q <= 1'b1;
		end else if (rpt_ready) begin
			rpt_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			rpt_q.report_kind      <= emit_kind_q;
			rpt_q.report_value     <= emit_val_q;
			rpt_q.pwm_duty         <= duty_q;
			rpt_q.emergency_active <= lock_q;
		end
	end

	assign rpt_valid = rpt_valid_q;
	assign rpt       = rpt_q;

endmodule

>>> dv/tb.sv
// self-checking testbench for serial_command_pwm_controller: directed command lines, then
// random command streams under four idling phases, checked against a built-in predictor
// depends on scpc_pkg and the rtl of serial_command_pwm_controller
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import scpc_pkg::*;

	// interface signals, all inputs known from time zero
	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      cmd_valid = 1'b0;
	logic      cmd_ready;
	cmd_item_t cmd       = '0;
	logic      rpt_valid;
	logic      rpt_ready = 1'b0;
	rpt_item_t rpt;

	// idling knobs, percent of cycles
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;

	// command word that asks for the temperature
	localparam string TEMP_CMD = {"leer", "_temp"};

	// predictor state: mirror of the line memory, lockout, percent and duty
	logic [7:0] line_buf [LINE_CAP_DEF];
	int         line_len    = 0;
	logic       lockout     = 1'b0;
	int         last_pct    = 0;
	logic [9:0] duty_now    = '0;

	// reports still owed by the block, oldest first
	rpt_item_t pending_reports [$];
	int        mismatch_count = 0;
	int        items_sent     = 0;

	serial_command_pwm_controller dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.rpt_valid (rpt_valid),
		.rpt_ready (rpt_ready),
		.rpt       (rpt)
	);

	initial forever #5 clk = ~clk;

	// watchdog, far beyond the slowest legal run
	initial begin
		#5_000_000;
		$display("== FAIL ==");
		$finish;
	end

	// does the gathered line equal the word, or start with it when prefix is set
	function automatic bit line_matches(string word, bit prefix);
		int k;
		if (line_len < word.len() || (!prefix && line_len != word.len()))
			return 1'b0;
		for (k = 0; k < word.len(); k++)
			if (line_buf[k] != word[k])
				return 1'b0;
		return 1'b1;
	endfunction

	// advance the predictor by one accepted command; returns 1 when a report follows
	function automatic bit predict_report(cmd_item_t c, output rpt_item_t r);
		bit is_temp;
		bit is_ctrl;
		bit hit;
		int temp_c;
		int digits;
		int acc;
		int scaled;
		int k;
		r   = '0;
		hit = 1'b0;
		if (c.req_type == REQ_EMERGENCY) begin
			// pin event: latch lockout, kill the duty, notice
			lockout  = 1'b1;
			duty_now = '0;
			hit      = 1'b1;
			r.report_kind = KIND_NOTICE;
		end else if (c.rx_byte == CHAR_NUL) begin
			// zero byte is dropped
			hit = 1'b0;
		end else if (c.rx_byte != CHAR_NEWLINE) begin
			// store and wrap at the line capacity
			if (line_len >= LINE_CAP_DEF)
				line_len = 0;
			line_buf[line_len] = c.rx_byte;
			line_len++;
			if (line_len >= LINE_CAP_DEF)
				line_len = 0;
		end else begin
			is_temp = line_matches(TEMP_CMD, 1'b0);
			is_ctrl = line_matches("ctrl:", 1'b1);
			if (lockout) begin
				if (line_matches("reanudar", 1'b0)) begin
					lockout = 1'b0;
				end else if (is_temp || is_ctrl) begin
					hit = 1'b1;
					r.report_kind = KIND_NOTICE;
				end
			end else if (is_temp) begin
				temp_c = (int'(c.adc_sample) * TEMP_SLOPE - TEMP_OFFSET) / 1024;
				hit = 1'b1;
				r.report_kind  = KIND_TEMP;
				r.report_value = temp_c[15:0];
			end else if (is_ctrl) begin
				// only one to three characters replace the percent
				digits = line_len - 5;
				if (digits >= 1 && digits <= 3) begin
					acc = 0;
					for (k = 0; k < digits; k++)
						acc = acc * 10 + (int'(line_buf[5 + k]) - int'(CHAR_ZERO));
					last_pct = acc;
				end
				scaled = last_pct * DUTY_SCALE / PCT_MAX;
				if (scaled < 0)
					scaled = 0;
				if (scaled > DUTY_MAX)
					scaled = DUTY_MAX;
				duty_now = scaled[9:0];
				hit = 1'b1;
				r.report_kind  = KIND_PERCENT;
				r.report_value = last_pct[15:0];
			end
			// every newline consumes the line
			line_len = 0;
		end
		r.pwm_duty         = duty_now;
		r.emergency_active = lockout;
		return hit;
	endfunction

	function automatic void log_mismatch(string what, logic signed [31:0] want,
			logic signed [31:0] got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t mismatch on %s: expected %0d got %0d", $realtime, what, want, got);
	endfunction

	// one command transfer, with random sender gaps; predicts at acceptance
	task automatic send_cmd(input logic req, input logic [7:0] b, input logic [9:0] adc);
		cmd_item_t item;
		rpt_item_t r;
		item.req_type   = req;
		item.rx_byte    = b;
		item.adc_sample = adc;
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd       <= item;
		cmd_valid <= 1'b1;
		@(posedge clk);
		while (!cmd_ready)
			@(posedge clk);
		if (predict_report(item, r))
			pending_reports.push_back(r);
		// dropped zero bytes do not count toward the item budget
		if (req == REQ_EMERGENCY || b != CHAR_NUL)
			items_sent++;
	endtask

	task automatic send_byte(input logic [7:0] b);
		send_cmd(REQ_BYTE, b, 10'($urandom_range(1023)));
	endtask

	// characters of a string, now and then with a stray zero byte in front
	task automatic send_text(input string s);
		int k;
		for (k = 0; k < s.len(); k++) begin
			if ($urandom_range(49) == 0)
				send_byte(CHAR_NUL);
			send_byte(s[k]);
		end
	endtask

	task automatic send_line(input string s);
		send_text(s);
		send_byte(CHAR_NEWLINE);
	endtask

	task automatic ask_temp(input logic [9:0] adc);
		send_text(TEMP_CMD);
		send_cmd(REQ_BYTE, CHAR_NEWLINE, adc);
	endtask

	task automatic pin_event();
		send_cmd(REQ_EMERGENCY, 8'($urandom_range(255)), 10'($urandom_range(1023)));
	endtask

	// any storable character: not zero and not newline
	function automatic logic [7:0] any_text_byte();
		logic [7:0] b;
		b = 8'($urandom_range(255, 1));
		if (b == CHAR_NEWLINE)
			b = 8'($urandom_range(255, 11));
		return b;
	endfunction

	// sender holds off until the block owes nothing
	task automatic wait_for_reports();
		cmd_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_reports.size() != 0);
	endtask

	// report checker: every rpt transfer against the oldest expectation
	always @(posedge clk) begin
		rpt_item_t want;
		if (arst_n && rpt_valid && rpt_ready) begin
			if (pending_reports.size() == 0) begin
				log_mismatch("unexpected report kind", -1, rpt.report_kind);
			end else begin
				want = pending_reports.pop_front();
				if (rpt.report_kind !== want.report_kind)
					log_mismatch("report_kind", want.report_kind, rpt.report_kind);
				if (rpt.report_value !== want.report_value)
					log_mismatch("report_value", want.report_value, rpt.report_value);
				if (rpt.pwm_duty !== want.pwm_duty)
					log_mismatch("pwm_duty", want.pwm_duty, rpt.pwm_duty);
				if (rpt.emergency_active !== want.emergency_active)
					log_mismatch("emergency_active", want.emergency_active,
						rpt.emergency_active);
			end
		end
	end

	// receiver back-pressure
	always @(posedge clk)
		rpt_ready <= ($urandom_range(99) >= recv_stall_pct);

	// empty lines and zero bytes give nothing; a zero inside a word is invisible
	task automatic test_blank_lines();
		send_byte(CHAR_NEWLINE);
		send_byte(CHAR_NUL);
		send_byte(CHAR_NEWLINE);
		send_text("ct");
		send_byte(CHAR_NUL);
		send_line("rl:5");
	endtask

	// converter extremes and the truncation around zero degrees
	task automatic test_temperature();
		ask_temp(10'd0);
		ask_temp(10'd1023);
		ask_temp(10'd274);
		ask_temp(10'd275);
		ask_temp(10'($urandom_range(1023)));
	endtask

	// percent parsing, saturation and kept percent on bad lengths
	task automatic test_duty_percent();
		send_line("ctrl:50");
		send_line("ctrl:100");
		send_line("ctrl:999");
		send_line("ctrl:");
		send_line("ctrl:1234");
		send_line("ctrl:!!");
		send_line("ctrl:zzz");
		// largest value from three top characters
		send_text("ctrl:");
		repeat (3) send_byte(8'hff);
		send_byte(CHAR_NEWLINE);
		// smallest storable characters
		send_text("ctrl:");
		repeat (3) send_byte(8'h01);
		send_byte(CHAR_NEWLINE);
		send_line("ctrl:7");
	endtask

	// lines that match nothing, and resume while not locked out
	task automatic test_unknown_lines();
		send_line({TEMP_CMD, "x"});
		send_line(TEMP_CMD.substr(0, 7));
		send_line({"L", TEMP_CMD.substr(1, 8)});
		send_line("ctrl");
		send_line("hola");
		send_line("reanudar");
	endtask

	// lockout entry, notices while locked, resume and the kept percent after it
	task automatic test_emergency_lockout();
		send_line("ctrl:60");
		pin_event();
		ask_temp(10'd600);
		send_line("ctrl:10");
		send_line("ctrlx");
		pin_event();
		send_line("reanudar");
		send_line("reanudar");
		send_line("ctrl:");
		ask_temp(10'd800);
	endtask

	// a full line wraps the write position back to the start
	task automatic test_line_wrap();
		repeat (LINE_CAP_DEF) send_byte("x");
		ask_temp(10'd900);
		repeat (LINE_CAP_DEF + 15) send_byte("y");
		send_byte(CHAR_NEWLINE);
	endtask

	// one random line: mostly well-formed commands with random content, some breakage
	task automatic send_random_line();
		int         pick;
		int         n;
		int         k;
		string      word;
		logic [7:0] b;
		pick = $urandom_range(99);
		if (pick < 7) begin
			pin_event();
		end else if (pick < 35) begin
			send_line(TEMP_CMD);
		end else if (pick < 70) begin
			if ($urandom_range(9) < 8)
				n = $urandom_range(3, 1);
			else if ($urandom_range(1) == 0)
				n = 0;
			else
				n = $urandom_range(5, 4);
			send_text("ctrl:");
			for (k = 0; k < n; k++) begin
				if ($urandom_range(9) < 8)
					b = CHAR_ZERO + 8'($urandom_range(9));
				else
					b = any_text_byte();
				send_byte(b);
			end
			send_byte(CHAR_NEWLINE);
		end else if (pick < 78) begin
			send_line("reanudar");
		end else if (pick < 88) begin
			// damaged command word: one character replaced or the last one lost
			case ($urandom_range(2))
				0: word = TEMP_CMD;
				1: word = "reanudar";
				default: word = "ctrl:5";
			endcase
			if ($urandom_range(1) == 0)
				word.putc($urandom_range(word.len() - 1), any_text_byte());
			else
				word = word.substr(0, word.len() - 2);
			send_line(word);
		end else begin
			// raw noise, may or may not end the line
			n = $urandom_range(40, 1);
			repeat (n) send_byte(8'($urandom_range(255)));
			if ($urandom_range(1) == 0)
				send_byte(CHAR_NEWLINE);
		end
	endtask

	task automatic run_random_phase(input int idle_pct, input int stall_pct, input int goal);
		int stop_at;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		stop_at        = items_sent + goal;
		while (items_sent < stop_at)
			send_random_line();
		// sender pauses until the block has caught up
		wait_for_reports();
	endtask

	task automatic finish_run();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		wait_for_reports();
		// room for a newline still being evaluated with nothing to report
		repeat (40) @(posedge clk);
		if (mismatch_count == 0 && pending_reports.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_blank_lines();
		test_temperature();
		test_duty_percent();
		test_unknown_lines();
		test_emergency_lockout();
		test_line_wrap();
		wait_for_reports();
		items_sent = 0;
		run_random_phase(0, 0, 360);
		run_random_phase(71, 0, 360);
		run_random_phase(0, 71, 360);
		run_random_phase(14, 14, 360);
		finish_run();
	end

endmodule

>>> filelist.f
rtl/scpc_pkg.sv
rtl/scpc_mac.sv
rtl/serial_command_pwm_controller.sv
dv/tb.sv
